[src/cps_pkg.sv]
// Shared types and constants for the column projection character segmenter.
// No dependencies; every other file of the block uses this package.
package cps_pkg;

  localparam int COORD_W = 12;
  localparam int WIDTH_W = 13;
  localparam int MAX_DIM = 4096;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic               pixel_black;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               end_of_column;
    logic               end_of_line;
  } pix_t;

  typedef struct packed {
    logic [COORD_W-1:0] box_x;
    logic [COORD_W-1:0] box_y;
    logic [WIDTH_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic               end_of_list;
  } res_t;

  // Results produced by one item: at most a box followed by the terminator.
  typedef struct packed {
    logic n0;
    logic n1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

[src/cps_if.sv]
// Valid/ready channel interfaces for pixels in and boxes out.
// Depends on cps_pkg for field widths.
interface cps_pix_if;
  logic                        valid;
  logic                        ready;
  logic                        pixel_black;
  logic [cps_pkg::COORD_W-1:0] row;
  logic [cps_pkg::COORD_W-1:0] column;
  logic                        end_of_column;
  logic                        end_of_line;

  modport source (output valid, pixel_black, row, column, end_of_column, end_of_line,
                  input ready);
  modport sink (input valid, pixel_black, row, column, end_of_column, end_of_line,
                output ready);
endinterface

interface cps_box_if;
  logic                        valid;
  logic                        ready;
  logic [cps_pkg::COORD_W-1:0] box_x;
  logic [cps_pkg::COORD_W-1:0] box_y;
  logic [cps_pkg::WIDTH_W-1:0] box_width;
  logic [cps_pkg::COORD_W-1:0] box_height;
  logic                        end_of_list;

  modport source (output valid, box_x, box_y, box_width, box_height, end_of_list,
                  input ready);
  modport sink (input valid, box_x, box_y, box_width, box_height, end_of_list,
                output ready);
endinterface

[src/cps_core.sv]
// Column projection state and box builder: one registered item per cycle while go is high.
// Depends on cps_pkg.
module cps_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  cps_pkg::pix_t  item,
  output cps_pkg::push_t push
);
  import cps_pkg::*;

  logic               in_char_r, in_char_nxt;
  logic               col_white_r, col_white_nxt;
  logic [COORD_W-1:0] col_top_r, col_top_nxt;
  logic [COORD_W-1:0] col_bot_r, col_bot_nxt;
  logic [COORD_W-1:0] box_start_r, box_start_nxt;
  logic [COORD_W-1:0] box_top_r, box_top_nxt;
  logic [COORD_W-1:0] box_bot_r, box_bot_nxt;
  logic               any_box_r, any_box_nxt;

  logic               cw_e;
  logic [COORD_W-1:0] ct_e, cb_e;
  logic               close, white_close, eol_box, box_emit, term;
  logic [WIDTH_W-1:0] end_x, width_raw, width_cap;
  logic [COORD_W-1:0] height;
  res_t               box_res, term_res;

  always_comb begin
    // fold in this pixel's black row
    cw_e = col_white_r;
    ct_e = col_top_r;
    cb_e = col_bot_r;
    if (item.pixel_black) begin
      if (col_white_r) begin
        ct_e = item.row;
      end
      cw_e = 1'b0;
      cb_e = item.row;
    end

    close       = item.end_of_column | item.end_of_line;
    white_close = close & cw_e & in_char_r;
    eol_box     = item.end_of_line & ~cw_e;
    box_emit    = white_close | eol_box;

    in_char_nxt   = in_char_r;
    col_white_nxt = cw_e;
    col_top_nxt   = ct_e;
    col_bot_nxt   = cb_e;
    box_start_nxt = box_start_r;
    box_top_nxt   = box_top_r;
    box_bot_nxt   = box_bot_r;
    any_box_nxt   = any_box_r;

    if (close) begin
      if (!cw_e) begin
        if (!in_char_r) begin
          box_start_nxt = item.column;
          box_top_nxt   = ct_e;
          box_bot_nxt   = cb_e;
          in_char_nxt   = 1'b1;
          any_box_nxt   = 1'b1;
        end else begin
          if (ct_e < box_top_r) begin
            box_top_nxt = ct_e;
          end
          if (cb_e > box_bot_r) begin
            box_bot_nxt = cb_e;
          end
        end
      end else if (in_char_r) begin
        in_char_nxt = 1'b0;
      end
      col_white_nxt = 1'b1;
      col_top_nxt   = '0;
      col_bot_nxt   = '0;
    end

    term = item.end_of_line & any_box_nxt;

    // a box closed by the line end reaches one past the last column
    end_x     = {1'b0, item.column} + WIDTH_W'(eol_box);
    width_raw = (end_x > {1'b0, box_start_nxt}) ? end_x - {1'b0, box_start_nxt} : '0;
    width_cap = (width_raw > WIDTH_W'(MAX_DIM)) ? WIDTH_W'(MAX_DIM) : width_raw;
    height    = (box_bot_nxt > box_top_nxt) ? box_bot_nxt - box_top_nxt : '0;

    box_res.box_x       = box_start_nxt;
    box_res.box_y       = box_top_nxt;
    box_res.box_width   = width_cap;
    box_res.box_height  = height;
    box_res.end_of_list = 1'b0;

    term_res             = '0;
    term_res.end_of_list = 1'b1;

    if (item.end_of_line) begin
      in_char_nxt = 1'b0;
      any_box_nxt = 1'b0;
    end

    push.n0 = go & (box_emit | term);
    push.n1 = go & box_emit & term;
    push.r0 = box_emit ? box_res : term_res;
    push.r1 = term_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_char_r   <= 1'b0;
      col_white_r <= 1'b1;
      col_top_r   <= '0;
      col_bot_r   <= '0;
      box_start_r <= '0;
      box_top_r   <= '0;
      box_bot_r   <= '0;
      any_box_r   <= 1'b0;
    end else if (go) begin
      in_char_r   <= in_char_nxt;
      col_white_r <= col_white_nxt;
      col_top_r   <= col_top_nxt;
      col_bot_r   <= col_bot_nxt;
      box_start_r <= box_start_nxt;
      box_top_r   <= box_top_nxt;
      box_bot_r   <= box_bot_nxt;
      any_box_r   <= any_box_nxt;
    end
  end

endmodule

[src/cps_fifo.sv]
// Result queue: takes up to two results a cycle, hands out one per transfer.
// Depends on cps_pkg.
module cps_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  cps_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output cps_pkg::res_t  out_res
);
  import cps_pkg::*;

  res_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [CNT_W-1:0] n_push;

  assign out_valid = (cnt_r != '0);
  assign out_res   = mem_r[rptr_r];
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign pop       = out_valid & out_ready;
  assign n_push    = CNT_W'(push.n0) + CNT_W'(push.n1);

  always_comb begin
    wptr_nxt = wptr_r + PTR_W'(n_push);
    rptr_nxt = rptr_r + PTR_W'(pop);
    cnt_nxt  = cnt_r + n_push - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n0) begin
      mem_r[wptr_r] <= push.r0;
    end
    if (push.n1) begin
      mem_r[wptr_r + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

[src/column_projection_char_segmenter.sv]
// Character segmenter by vertical projection over one text line of pixels.
// Uses cps_pkg, cps_pix_if / cps_box_if, cps_core and cps_fifo.
//
// in_pix carries one binary pixel per transfer in column-major order, with
// its row, its column and end_of_column / end_of_line marks. A run of columns
// holding any black pixel forms one character box; the box goes out on out_box
// when a white column or the line end closes it. After the line, an all-zero
// item with end_of_list set follows if the line held any box.
//
// Throughput: one pixel per cycle while in_pix.ready is high. A pixel is
// registered on transfer, processed once the queue has room for its results,
// and its results are written into the queue, which drives out_box.
// Each pixel may produce up to two results; they wait in a four-entry queue.
// in_pix.ready drops only while a pixel sits in the input register and the
// queue has fewer than two free entries, i.e. when the receiver stalls long
// enough for results to pile up. Results are never dropped.
// Reset (rst_n low, synchronous) empties the queue and the input register and
// returns the segmenter state to the start of a line.
module column_projection_char_segmenter (
  input  logic           clk,
  input  logic           rst_n,
  cps_pix_if.sink        in_pix,
  cps_box_if.source      out_box
);
  import cps_pkg::*;

  logic  s1_v_r;
  pix_t  s1_r;
  logic  room;
  logic  go;
  push_t push;
  res_t  head;

  assign go           = s1_v_r & room;
  assign in_pix.ready = ~s1_v_r | go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_pix.ready) begin
      s1_v_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.ready && in_pix.valid) begin
      s1_r.pixel_black   <= in_pix.pixel_black;
      s1_r.row           <= in_pix.row;
      s1_r.column        <= in_pix.column;
      s1_r.end_of_column <= in_pix.end_of_column;
      s1_r.end_of_line   <= in_pix.end_of_line;
    end
  end

  cps_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (s1_r),
    .push  (push)
  );

  cps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_box.valid),
    .out_ready (out_box.ready),
    .out_res   (head)
  );

  assign out_box.box_x       = head.box_x;
  assign out_box.box_y       = head.box_y;
  assign out_box.box_width   = head.box_width;
  assign out_box.box_height  = head.box_height;
  assign out_box.end_of_list = head.end_of_list;

  // a held-off input means a pixel is waiting in the input register
  a_ready_low_held : assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> s1_v_r)
    else $error("input stalled with empty input register");

  // a second result in one cycle only follows a first one
  a_pair_order : assert property (@(posedge clk) disable iff (!rst_n)
    push.n1 |-> (push.n0 && !push.r0.end_of_list && push.r1.end_of_list))
    else $error("bad result pair ordering");

  // the terminator only comes from the last pixel of a line
  a_term_eol : assert property (@(posedge clk) disable iff (!rst_n)
    (push.n0 && push.r0.end_of_list) |-> (go && s1_r.end_of_line))
    else $error("terminator without end of line");

  // results are only pushed while the queue has room for two
  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    push.n0 |-> room)
    else $error("result pushed into a full queue");

endmodule
